// ===== hw/rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CNT_W       = 3;

	localparam logic [7:0] LEAD2_MASK  = 8'h1F;
	localparam logic [7:0] LEAD3_MASK  = 8'h0F;
	localparam logic [7:0] LEAD4_MASK  = 8'h07;
	localparam logic [1:0] CONT_TAG    = 2'b10;
	localparam logic [2:0] LEN_NONE    = 3'd0;
	localparam logic [2:0] LEN_2       = 3'd2;
	localparam logic [2:0] LEN_3       = 3'd3;
	localparam logic [2:0] LEN_4       = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic            raw_byte;
		logic            decode_error;
		logic            string_end;
		logic            last_of_run;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] result_list_t;

endpackage

// ===== hw/rtl/utf8d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_core
// Decoder state and the single-pass decode of one beat into up to four
// results, with the mode register.
// ----------------------------------------------------------------------------
module utf8d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_string,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output utf8d_pkg::result_list_t       res,
	output logic [utf8d_pkg::CNT_W-1:0]   res_n
);

	logic        keep_q;
	logic [7:0]  lead_q;
	logic [2:0]  exp_len_q;
	logic [1:0]  seen_q;
	logic [20:0] pv_q;
	logic        drop_q;

	logic [7:0]  lead_d;
	logic [2:0]  exp_len_d;
	logic [1:0]  seen_d;
	logic [20:0] pv_d;
	logic        drop_d;

	logic        is_cont;
	logic [20:0] pv_shift;
	logic [2:0]  seen_inc;
	logic        do_fail;
	logic        do_lead;
	logic [1:0]  conts;

	assign is_cont  = (data_byte[7:6] == utf8d_pkg::CONT_TAG);
	assign pv_shift = {pv_q[14:0], data_byte[5:0]};
	assign seen_inc = {1'b0, seen_q} + 3'd1;
	assign conts    = seen_q - 2'd1;

	always_comb begin
		res       = '0;
		res_n     = '0;
		lead_d    = lead_q;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		pv_d      = pv_q;
		drop_d    = drop_q;
		do_fail   = 1'b0;
		do_lead   = 1'b0;

		if (end_of_string) begin
			do_fail = !drop_q && (exp_len_q != utf8d_pkg::LEN_NONE);
		end else if (drop_q) begin
			do_fail = 1'b0;
		end else if (exp_len_q == utf8d_pkg::LEN_NONE) begin
			do_lead = 1'b1;
		end else if (is_cont) begin
			pv_d   = pv_shift;
			seen_d = seen_inc[1:0];
			if (seen_inc >= exp_len_q) begin
				res[res_n[1:0]].codepoint = pv_shift;
				res_n     = res_n + 3'd1;
				lead_d    = '0;
				exp_len_d = utf8d_pkg::LEN_NONE;
				seen_d    = '0;
				pv_d      = '0;
			end
		end else begin
			do_fail = 1'b1;
			do_lead = keep_q;
		end

		// report an open sequence that cannot complete
		if (do_fail) begin
			if (keep_q) begin
				res[res_n[1:0]].codepoint = {13'd0, lead_q};
				res[res_n[1:0]].raw_byte  = 1'b1;
				res_n = res_n + 3'd1;
				if (conts == 2'd2) begin
					res[res_n[1:0]].codepoint = {13'd0, utf8d_pkg::CONT_TAG, pv_q[11:6]};
					res[res_n[1:0]].raw_byte  = 1'b1;
					res_n = res_n + 3'd1;
				end
				if (conts != 2'd0) begin
					res[res_n[1:0]].codepoint = {13'd0, utf8d_pkg::CONT_TAG, pv_q[5:0]};
					res[res_n[1:0]].raw_byte  = 1'b1;
					res_n = res_n + 3'd1;
				end
			end else begin
				res[res_n[1:0]].decode_error = 1'b1;
				res_n  = res_n + 3'd1;
				drop_d = 1'b1;
			end
			lead_d    = '0;
			exp_len_d = utf8d_pkg::LEN_NONE;
			seen_d    = '0;
			pv_d      = '0;
		end

		// new lead byte
		if (do_lead) begin
			if (!data_byte[7]) begin
				res[res_n[1:0]].codepoint = {13'd0, data_byte};
				res_n = res_n + 3'd1;
			end else if (data_byte inside {[8'hC0:8'hF7]}) begin
				lead_d = data_byte;
				seen_d = 2'd1;
				if (data_byte <= 8'hDF) begin
					exp_len_d = utf8d_pkg::LEN_2;
					pv_d      = {13'd0, data_byte & utf8d_pkg::LEAD2_MASK};
				end else if (data_byte <= 8'hEF) begin
					exp_len_d = utf8d_pkg::LEN_3;
					pv_d      = {13'd0, data_byte & utf8d_pkg::LEAD3_MASK};
				end else begin
					exp_len_d = utf8d_pkg::LEN_4;
					pv_d      = {13'd0, data_byte & utf8d_pkg::LEAD4_MASK};
				end
			end else if (keep_q) begin
				res[res_n[1:0]].codepoint = {13'd0, data_byte};
				res[res_n[1:0]].raw_byte  = 1'b1;
				res_n = res_n + 3'd1;
			end else begin
				res[res_n[1:0]].decode_error = 1'b1;
				res_n  = res_n + 3'd1;
				drop_d = 1'b1;
			end
		end

		if (end_of_string) begin
			lead_d    = '0;
			exp_len_d = utf8d_pkg::LEN_NONE;
			seen_d    = '0;
			pv_d      = '0;
			drop_d    = 1'b0;
			res[res_n[1:0]].string_end = 1'b1;
			res_n = res_n + 3'd1;
		end

		if (res_n != '0) begin
			res[res_n[1:0] - 2'd1].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q    <= 1'b1;
			lead_q    <= '0;
			exp_len_q <= utf8d_pkg::LEN_NONE;
			seen_q    <= '0;
			pv_q      <= '0;
			drop_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_wdata;
			end
			if (accept) begin
				lead_q    <= lead_d;
				exp_len_q <= exp_len_d;
				seen_q    <= seen_d;
				pv_q      <= pv_d;
				drop_q    <= drop_d;
			end
		end
	end

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with keep and strict handling of bad input.
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle, while the output side is ready, and turns
// it in a single pass into zero to four result beats held in a four-entry
// output buffer. A clean stream runs at one byte per cycle while m_tready
// is high; a byte that gives more than one result holds the input off while
// the buffer drains, one result beat per cycle while m_tready is high.
// The input is taken again as soon as the last buffered result leaves.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // codepoint, zero pad
	output logic [2:0]  m_tuser,   // raw_byte, decode_error, string_end
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_we,
	input  logic        cfg_wdata  // keep_invalid_bytes
);

	utf8d_pkg::result_list_t       res;
	logic [utf8d_pkg::CNT_W-1:0]   res_n;
	utf8d_pkg::result_list_t       buf_q;
	logic [utf8d_pkg::CNT_W-1:0]   cnt_q;
	logic                          accept;
	logic                          pop;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (cnt_q == '0) || ((cnt_q == 3'd1) && m_tready);
	assign accept   = s_tvalid && s_tready;

	utf8d_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.end_of_string (s_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.res           (res),
		.res_n         (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= res_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= res;
		end else if (pop) begin
			buf_q <= {utf8d_pkg::result_t'('0), buf_q[utf8d_pkg::MAX_RESULTS-1:1]};
		end
	end

	assign m_tdata = {3'd0, buf_q[0].codepoint};
	assign m_tuser = {buf_q[0].string_end, buf_q[0].decode_error, buf_q[0].raw_byte};
	assign m_tlast = buf_q[0].last_of_run;

	a_cnt_range : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("output buffer count out of range");

	a_last_at_tail : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == 3'd1)))
		else $error("last beat flag not on the final buffered result");

	a_end_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tlast && m_tdata == 24'd0))
		else $error("end marker not last or carries a codepoint");

	a_error_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == 24'd0 && !m_tuser[0]))
		else $error("error result carries data");

endmodule
